// File: rtl/usart_serial_controller_macros.svh
// assertion macros for the usart serial controller
// no dependencies; included by rtl modules that assert
`ifndef USART_SERIAL_CONTROLLER_MACROS_SVH
`define USART_SERIAL_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
`define USC_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define USC_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("%m failed");
`else
`define USC_ASSERT_IMPL(label, clk, rst_n, prop)
`define USC_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// File: rtl/usc_pkg.sv
// shared codes for the usart serial controller
// no dependencies
`default_nettype none
package usc_pkg;
  localparam logic [3:0] OP_WR_CTRL = 4'd0;
  localparam logic [3:0] OP_WR_DATA = 4'd1;
  localparam logic [3:0] OP_RD_STAT = 4'd2;
  localparam logic [3:0] OP_RD_DATA = 4'd3;
  localparam logic [3:0] OP_RXD     = 4'd4;
  localparam logic [3:0] OP_TXC     = 4'd5;
  localparam logic [3:0] OP_RXC     = 4'd6;
  localparam logic [3:0] OP_DSR     = 4'd7;
  localparam logic [3:0] OP_CTS     = 4'd8;
  localparam logic [3:0] OP_SYNDET  = 4'd9;

  localparam logic [2:0] TX_NONE = 3'd0, TX_START = 3'd1, TX_DATA = 3'd2, TX_PARITY = 3'd3;
  localparam logic [2:0] TX_STOP = 3'd4, TX_STOP15 = 3'd5, TX_STOP2 = 3'd6, TX_IDLE = 3'd7;
  localparam logic [2:0] RX_NONE = 3'd0, RX_WAIT = 3'd1, RX_START = 3'd2, RX_DATA = 3'd3;
  localparam logic [2:0] RX_PARITY = 3'd4, RX_STOP = 3'd5, RX_HUNT = 3'd6;

  localparam int ST_TXR = 0, ST_RXR = 1, ST_TXE = 2, ST_PE = 3;
  localparam int ST_OE = 4, ST_FE = 5, ST_SYN = 6, ST_BRK = 7;
  localparam int P_RXD = 0, P_TXC = 1, P_RXC = 2, P_DSR = 3, P_CTS = 4, P_TXD = 5;
  localparam logic [5:0] PINS_RESET = 6'h3D;
  localparam logic [7:0] MODE_RESET = 8'h4E;
  localparam logic [7:0] NO_READ = 8'hFF;

  // event word: tuser operation[3:0] on top of tdata {pad, level, data[7:0]}
  typedef struct packed {
    logic [3:0] operation;
    logic [6:0] pad;
    logic       level;
    logic [7:0] data;
  } in_word_t;
endpackage
`default_nettype wire

// File: rtl/usart_serial_controller.sv
// 8251-style usart event processor, top level
// depends on usc_pkg and usart_serial_controller_macros.svh
//
// usage: each input transaction carries one event (cpu register access or a
// pin level change): the operation in in_tuser, byte and level in in_tdata.
// every event yields exactly one result transaction on out_* with the read
// byte and the current pin levels.
// the event is processed in the cycle it is accepted and its result
// is registered, so it appears in the next cycle. throughput: one event per
// cycle, limited only by the one-deep result register; a new event is taken
// whenever the result register is empty or is being drained in that cycle.
// a stalled receiver (out_tready low) holds the result and, once the result
// register is full, holds in_tready low.
// reset (rst_n low, synchronous) loads mode 0x4E, clears command, sync and
// status state, sets all pins high except txc and empties the result register.
`default_nettype none
`include "usart_serial_controller_macros.svh"
module usart_serial_controller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [15:0] in_tdata,   // data[7:0], level[8], zero pad
  input  wire logic [3:0]  in_tuser,   // operation[3:0]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [23:0] out_tdata   // read_value[7:0], txd, txrdy, txempty, rxrdy,
                                       // dtr_n, rts_n, syn_brk, setup_phase[16:15], pad
);
  import usc_pkg::*;

  logic [7:0] mode_r, cmd_r, s1_r, s2_r, txh_r, rxh_r, txs_r, rxs_r, st_r;
  logic [1:0] ip_r, txt_r, rxt_r, brk_r;
  logic [2:0] txp_r, rxp_r;
  logic [3:0] txb_r, rxb_r;
  logic [6:0] txr_r, rxr_r;
  logic       txpb_r, rxpb_r, txbf_r;
  logic [5:0] pin_r;
  logic [23:0] out_r;
  logic       ov_r;

  logic [7:0] mode_nxt, cmd_nxt, s1_nxt, s2_nxt, txh_nxt, rxh_nxt, txs_nxt, rxs_nxt, st_nxt;
  logic [1:0] ip_nxt, txt_nxt, rxt_nxt, brk_nxt;
  logic [2:0] txp_nxt, rxp_nxt;
  logic [3:0] txb_nxt, rxb_nxt;
  logic [6:0] txr_nxt, rxr_nxt;
  logic       txpb_nxt, rxpb_nxt, txbf_nxt;
  logic [5:0] pin_nxt;
  logic [23:0] out_nxt;

  in_word_t   iw;
  logic       acc;
  assign iw = in_word_t'({in_tuser, in_tdata});
  assign in_tready = !ov_r || out_tready;
  assign acc = in_tvalid && in_tready;
  assign out_tvalid = ov_r;
  assign out_tdata = out_r;

  always_comb begin
    logic [7:0] mode, cmd, s1, s2, txh, rxh, txs, rxs, st, rd;
    logic [1:0] ip, txt, rxt, brk;
    logic [2:0] txp, rxp;
    logic [3:0] txb, rxb, n;
    logic [6:0] txr, rxr, f;
    logic       txpb, rxpb, txbf, old, rxd, lv, sb, go, matched;
    logic [5:0] pin;
    logic       hunt_rq, hunt_sec, data_rq, found_rq, found_hunt, char_rq, sce_rq;
    logic       txa_rq, txsync_rq;
    mode = mode_r; cmd = cmd_r; s1 = s1_r; s2 = s2_r; txh = txh_r; rxh = rxh_r;
    txs = txs_r; rxs = rxs_r; st = st_r; ip = ip_r; txt = txt_r; rxt = rxt_r;
    brk = brk_r; txp = txp_r; rxp = rxp_r; txb = txb_r; rxb = rxb_r; txr = txr_r;
    rxr = rxr_r; txpb = txpb_r; rxpb = rxpb_r; txbf = txbf_r; pin = pin_r;
    rd = NO_READ; lv = iw.level; old = 1'b0; rxd = pin_r[P_RXD];
    hunt_rq = 1'b0; hunt_sec = 1'b0; data_rq = 1'b0; found_rq = 1'b0;
    found_hunt = 1'b0; char_rq = 1'b0; sce_rq = 1'b0; txa_rq = 1'b0;
    txsync_rq = 1'b0; go = 1'b0; matched = 1'b0; sb = 1'b0;
    n = {2'b00, mode_r[3:2]} + 4'd5;
    case (mode_r[1:0])
      2'd0: f = 7'd0;
      2'd1: f = 7'd1;
      2'd2: f = 7'd16;
      default: f = 7'd64;
    endcase
    case (iw.operation)
      OP_WR_CTRL: begin
        if (ip_r == 2'd0) begin
          mode = iw.data;
          n = {2'b00, mode[3:2]} + 4'd5;
          case (mode[1:0])
            2'd0: f = 7'd0;
            2'd1: f = 7'd1;
            2'd2: f = 7'd16;
            default: f = 7'd64;
          endcase
          rxb = n + {3'd0, mode[4]}; txb = n;
          st = 8'h05; rxp = RX_NONE; rxt = 2'd0; brk = 2'd0;
          txp = TX_NONE; txt = 2'd0; txbf = 1'b0; pin = PINS_RESET;
          if (mode[1:0] == 2'd0) ip = 2'd1;
          else begin
            ip = 2'd3; txa_rq = 1'b1; rxp = RX_WAIT;
          end
        end else if (ip_r != 2'd3) begin
          if (ip_r == 2'd1) s1 = iw.data; else s2 = iw.data;
          if (ip_r == 2'd1 && !mode_r[7]) ip = 2'd2;
          else begin
            ip = 2'd3; txsync_rq = 1'b1; hunt_rq = 1'b1;
          end
        end else begin
          cmd = iw.data;
          if (iw.data[6]) ip = 2'd0;
          else begin
            if (iw.data[4]) st = st & 8'hC7;
            if (iw.data[3]) begin
              txbf = 1'b1; pin[P_TXD] = 1'b0;
            end else if (txbf_r) begin
              txbf = 1'b0; pin[P_TXD] = 1'b1;
              if (mode_r[1:0] == 2'd0) txsync_rq = 1'b1; else txa_rq = 1'b1;
            end
            if (mode_r[1:0] == 2'd0 && iw.data[7]) hunt_rq = 1'b1;
          end
        end
      end
      OP_WR_DATA: begin
        if (ip_r == 2'd3) begin
          txh = iw.data; st[ST_TXE] = 1'b0; st[ST_TXR] = 1'b0;
        end
      end
      OP_RD_STAT: begin
        rd = {!pin_r[P_DSR], st_r[6:0]};
        if (mode_r[1:0] == 2'd0 && !mode_r[6]) st[ST_SYN] = 1'b0;
      end
      OP_RD_DATA: begin
        if (st_r[ST_RXR]) begin
          rd = rxh_r; st[ST_RXR] = 1'b0;
        end
      end
      OP_RXD: begin
        if (mode_r[1:0] != 2'd0 && rxp_r == RX_WAIT && pin_r[P_RXD] && !lv) begin
          rxp = RX_START; rxr = (f > 7'd1) ? {1'b0, f[6:1]} : f;
        end
        if (mode_r[1:0] != 2'd0 && lv) begin
          st[ST_BRK] = 1'b0; brk = 2'd0;
        end
        pin[P_RXD] = lv;
      end
      OP_TXC: begin
        old = pin_r[P_TXC];
        pin[P_TXC] = lv;
        if (ip_r == 2'd3 && !txbf_r && old != lv && !lv) begin
          go = !pin_r[P_CTS] && cmd_r[0];
          if (mode_r[1:0] == 2'd0) begin
            if (txp_r == TX_DATA) begin
              if (go || txb_r != n) begin
                pin[P_TXD] = txs_r[0]; txs = {1'b0, txs_r[7:1]};
                txb = txb_r - 4'd1;
                if (txb == 4'd0) begin
                  if (mode_r[4]) txp = TX_PARITY; else txsync_rq = 1'b1;
                end
              end
            end else if (txp_r == TX_PARITY) begin
              pin[P_TXD] = txpb_r; txsync_rq = 1'b1;
            end
          end else if (txr_r > 7'd1) txr = txr_r - 7'd1;
          else begin
            txr = f;
            case (txp_r)
              TX_START: if (go) begin
                pin[P_TXD] = 1'b0; txp = TX_DATA;
              end
              TX_DATA: begin
                pin[P_TXD] = txs_r[0]; txs = {1'b0, txs_r[7:1]};
                txb = txb_r - 4'd1;
                if (txb == 4'd0) txp = mode_r[4] ? TX_PARITY : TX_STOP;
              end
              TX_PARITY: begin
                pin[P_TXD] = txpb_r; txp = TX_STOP;
              end
              TX_STOP: begin
                pin[P_TXD] = 1'b1;
                if (mode_r[7:6] == 2'd2) txp = TX_STOP15;
                else if (mode_r[7:6] == 2'd3) txp = TX_STOP2;
                else txp = TX_IDLE;
              end
              TX_STOP15, TX_STOP2: begin
                if (txp_r == TX_STOP15 && f > 7'd1) txr = {1'b0, f[6:1]};
                pin[P_TXD] = 1'b1; txp = TX_IDLE;
              end
              TX_IDLE: txa_rq = 1'b1;
              default: ;
            endcase
          end
        end
      end
      OP_RXC: begin
        old = pin_r[P_RXC];
        pin[P_RXC] = lv;
        if (ip_r == 2'd3 && old != lv && lv) begin
          go = 1'b1;
          if (mode_r[1:0] != 2'd0) begin
            if (rxr_r > 7'd1) begin
              rxr = rxr_r - 7'd1; go = 1'b0;
            end else rxr = f;
          end
          if (go) begin
            case (rxp_r)
              RX_HUNT: if (mode_r[1:0] == 2'd0 && !mode_r[6]) begin
                rxb = rxb_r - 4'd1;
                if (rxb == 4'd0 && mode_r[4]) begin
                  if (rxpb_r == rxd) begin
                    found_rq = 1'b1; found_hunt = 1'b1;
                  end else hunt_rq = 1'b1;
                end else if (rxs_r[0] == rxd) begin
                  rxs = {1'b0, rxs_r[7:1]};
                  if (rxb == 4'd0) begin
                    found_rq = 1'b1; found_hunt = 1'b1;
                  end
                end else hunt_rq = 1'b1;
              end
              RX_WAIT: if (!rxd && brk_r != 2'd0) begin
                rxp = RX_START; rxr = (f > 7'd1) ? {1'b0, f[6:1]} : f;
              end
              RX_START: begin
                if (rxd) rxp = RX_WAIT;
                else begin
                  rxp = RX_DATA; rxs = 8'd0; rxb = n;
                end
              end
              RX_DATA: begin
                rxs = {rxd, rxs_r[7:1]};
                rxb = rxb_r - 4'd1;
                if (rxb == 4'd0) begin
                  rxs = rxs >> (4'd8 - n);
                  if (mode_r[4]) begin
                    rxp = RX_PARITY; rxpb = 1'b0;
                  end else if (mode_r[1:0] == 2'd0) sce_rq = 1'b1;
                  else rxp = RX_STOP;
                end
              end
              RX_PARITY: begin
                if (rxd != rxpb_r) st[ST_PE] = 1'b1;
                if (mode_r[1:0] == 2'd0) sce_rq = 1'b1; else rxp = RX_STOP;
              end
              RX_STOP: begin
                if (!rxd) begin
                  st[ST_FE] = 1'b1;
                  if (brk_r != 2'd0) begin
                    brk = 2'd2; st[ST_BRK] = 1'b1;
                  end else brk = 2'd1;
                end
                char_rq = 1'b1; rxp = RX_WAIT;
              end
              default: ;
            endcase
          end
        end
      end
      OP_DSR: pin[P_DSR] = lv;
      OP_CTS: pin[P_CTS] = lv;
      OP_SYNDET: begin
        if (mode_r[1:0] == 2'd0 && mode_r[6] && st_r[ST_SYN] != lv) begin
          st[ST_SYN] = lv;
          if (lv) data_rq = 1'b1;
        end
      end
      default: ;
    endcase
    // receive parity computed on assembled character
    if (rxp == RX_PARITY && rxp_r == RX_DATA) begin
      rxpb = 1'b0;
      for (int i = 0; i < 8; i++) if (4'(i) < n) rxpb = rxpb ^ rxs[i];
      rxpb = mode[5] ? rxpb : !rxpb;
    end
    if (sce_rq) char_rq = 1'b1;
    // store the finished character before the shift register is reused
    if (char_rq) begin
      rxh = rxs;
      if (st[ST_RXR]) st[ST_OE] = 1'b1;
      st[ST_RXR] = 1'b1;
    end
    // sync character end: check for sync match
    if (sce_rq) begin
      matched = (rxt_r == 2'd1 && rxs == s1_r) || (rxt_r == 2'd2 && rxs == s2_r);
      if (matched) found_rq = 1'b1;
      else begin
        rxp = RX_DATA; rxb = n; rxs = 8'd0;
      end
    end
    if (found_rq) begin
      if (rxt_r == 2'd1 && !mode_r[7]) begin
        hunt_sec = 1'b1;
        if (found_hunt) hunt_rq = 1'b1;
        else data_rq = 1'b1;
      end else begin
        data_rq = 1'b1; st[ST_SYN] = 1'b1;
      end
    end
    if (hunt_rq) begin
      rxp = RX_HUNT;
      if (mode[1:0] == 2'd0 && !mode[6]) begin
        rxt = hunt_sec ? 2'd2 : 2'd1;
        rxs = hunt_sec ? s2 : s1;
        rxpb = 1'b0;
        for (int i = 0; i < 8; i++) if (4'(i) < n) rxpb = rxpb ^ rxs[i];
        rxpb = mode[5] ? rxpb : !rxpb;
        rxb = n + {3'd0, mode[4]};
      end else rxt = 2'd0;
      st[ST_RXR] = 1'b0;
    end else if (data_rq) begin
      rxp = RX_DATA; rxt = hunt_sec ? 2'd2 : 2'd1; rxb = n; rxs = 8'd0;
    end
    if (txsync_rq) begin
      if (txt_r == 2'd1 && !mode[7]) begin
        txt = 2'd2; txs = s2;
      end else if (!st[ST_TXR]) begin
        txt = 2'd0; txs = txh; st[ST_TXR] = 1'b1;
      end else begin
        txt = 2'd1; txs = s1; st[ST_TXE] = 1'b1;
      end
      txp = TX_DATA; txb = n;
    end
    if (txa_rq) begin
      if (!st[ST_TXR]) begin
        txp = TX_START; txs = txh; txb = n; st[ST_TXR] = 1'b1;
      end else begin
        st[ST_TXE] = 1'b1; txp = TX_IDLE;
      end
      txr = f;
      if (iw.operation == OP_TXC && txp == TX_START && !pin[P_CTS] && cmd[0]) begin
        pin[P_TXD] = 1'b0; txp = TX_DATA;
      end
    end
    if (txsync_rq || txa_rq) begin
      txpb = 1'b0;
      for (int i = 0; i < 8; i++) if (4'(i) < n) txpb = txpb ^ txs[i];
      txpb = mode[5] ? txpb : !txpb;
    end
    if (mode[1:0] == 2'd0 && !mode[6]) sb = st[ST_SYN];
    else if (mode[1:0] != 2'd0) sb = st[ST_BRK];
    else sb = 1'b0;
    out_nxt = {7'd0, ip, sb, !cmd[5], !cmd[1], st[ST_RXR], st[ST_TXE],
               st[ST_TXR] && cmd[0] && !pin[P_CTS], pin[P_TXD], rd};
    mode_nxt = mode; cmd_nxt = cmd; s1_nxt = s1; s2_nxt = s2; txh_nxt = txh;
    rxh_nxt = rxh; txs_nxt = txs; rxs_nxt = rxs; st_nxt = st; ip_nxt = ip;
    txt_nxt = txt; rxt_nxt = rxt; brk_nxt = brk; txp_nxt = txp; rxp_nxt = rxp;
    txb_nxt = txb; rxb_nxt = rxb; txr_nxt = txr; rxr_nxt = rxr; txpb_nxt = txpb;
    rxpb_nxt = rxpb; txbf_nxt = txbf; pin_nxt = pin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET; cmd_r <= '0; s1_r <= '0; s2_r <= '0; txs_r <= '0;
      rxs_r <= '0; st_r <= '0; ip_r <= '0; txt_r <= '0; rxt_r <= '0; brk_r <= '0;
      txp_r <= TX_NONE; rxp_r <= RX_NONE; txb_r <= '0; rxb_r <= '0; txr_r <= '0;
      rxr_r <= '0; txpb_r <= 1'b0; rxpb_r <= 1'b0; txbf_r <= 1'b0;
      pin_r <= PINS_RESET; ov_r <= 1'b0;
    end else begin
      if (acc) begin
        mode_r <= mode_nxt; cmd_r <= cmd_nxt; s1_r <= s1_nxt; s2_r <= s2_nxt;
        txs_r <= txs_nxt; rxs_r <= rxs_nxt; st_r <= st_nxt; ip_r <= ip_nxt;
        txt_r <= txt_nxt; rxt_r <= rxt_nxt; brk_r <= brk_nxt; txp_r <= txp_nxt;
        rxp_r <= rxp_nxt; txb_r <= txb_nxt; rxb_r <= rxb_nxt; txr_r <= txr_nxt;
        rxr_r <= rxr_nxt; txpb_r <= txpb_nxt; rxpb_r <= rxpb_nxt;
        txbf_r <= txbf_nxt; pin_r <= pin_nxt;
      end
      if (acc) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (acc) begin
      txh_r <= txh_nxt; rxh_r <= rxh_nxt; out_r <= out_nxt;
    end
  end

  `USC_ASSERT_NEXT(a_hold, clk, rst_n, ov_r && !out_tready, ov_r && $stable(out_r))
  `USC_ASSERT_NEXT(a_acc_valid, clk, rst_n, acc, ov_r)
  `USC_ASSERT_IMPL(a_break_low, clk, rst_n, txbf_r |-> !pin_r[P_TXD])
endmodule
`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench for the 8251-style usart event processor
// depends on usc_pkg and usart_serial_controller; streams random and directed
// cpu accesses and pin events, predicts every result and scores it in order
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import usc_pkg::*;

  localparam int CMD_TXEN = 0, CMD_DTR = 1, CMD_SBRK = 3, CMD_ERST = 4;
  localparam int CMD_RTS = 5, CMD_IRES = 6, CMD_HUNT = 7;
  localparam logic [7:0] CMD_IRES_WORD = 8'h40;

  typedef struct packed {
    logic [1:0] phase;
    logic       syn_brk;
    logic       rts_n;
    logic       dtr_n;
    logic       rxrdy;
    logic       txempty;
    logic       txrdy;
    logic       txd;
    logic [7:0] rd;
  } usart_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [3:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  usart_serial_controller uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  in_word_t      pending_events[$];
  usart_result_t expected_results[$];
  int            total_events;
  int            accepted_events = 0;
  int            errors = 0;
  bit            took = 1'b0;

  // ---------------------------------------------------------------- predictor
  logic [7:0] mode_reg, cmd_reg, syn1, syn2, txh, rxh, txsr, rxsr, stat;
  logic [1:0] setup, txtag, rxtag, brkcnt;
  logic [2:0] txph, rxph;
  logic [3:0] txbits, rxbits;
  logic [6:0] txcnt, rxcnt;
  logic       txpar, rxpar, txbrk;
  logic [5:0] pins;

  function automatic bit is_sync();
    return mode_reg[1:0] == 2'd0;
  endfunction
  function automatic bit int_sync();
    return is_sync() && !mode_reg[6];
  endfunction
  function automatic bit two_sync();
    return !mode_reg[7];
  endfunction
  function automatic logic [3:0] char_len();
    return {2'b00, mode_reg[3:2]} + 4'd5;
  endfunction
  function automatic logic [6:0] clk_factor();
    case (mode_reg[1:0])
      2'd0: return 7'd0;
      2'd1: return 7'd1;
      2'd2: return 7'd16;
      default: return 7'd64;
    endcase
  endfunction
  function automatic logic char_parity(logic [7:0] v);
    logic [7:0] mask;
    logic p;
    mask = 8'hFF >> (4'd8 - char_len());
    p = ^(v & mask);
    return mode_reg[5] ? p : ~p;
  endfunction
  function automatic bit tx_allowed();
    return !pins[P_CTS] && cmd_reg[CMD_TXEN];
  endfunction

  task automatic reset_model();
    mode_reg = MODE_RESET; cmd_reg = '0; syn1 = '0; syn2 = '0; setup = '0;
    txh = '0; rxh = '0; txsr = '0; rxsr = '0; txph = TX_NONE; txtag = '0;
    rxph = RX_NONE; rxtag = '0; txbits = '0; rxbits = '0; txcnt = '0; rxcnt = '0;
    txpar = 0; rxpar = 0; stat = '0; brkcnt = '0; txbrk = 0; pins = PINS_RESET;
  endtask

  task automatic load_async_char();
    if (!stat[ST_TXR]) begin
      txph = TX_START;
      txsr = txh;
      txpar = char_parity(txsr);
      txbits = char_len();
      stat[ST_TXR] = 1;
    end else begin
      stat[ST_TXE] = 1;
      txph = TX_IDLE;
    end
    txcnt = clk_factor();
  endtask

  task automatic load_sync_char();
    if (txtag == 2'd1 && two_sync()) begin
      txtag = 2'd2;
      txsr = syn2;
    end else if (!stat[ST_TXR]) begin
      txtag = 2'd0;
      txsr = txh;
      stat[ST_TXR] = 1;
    end else begin
      txtag = 2'd1;
      txsr = syn1;
      stat[ST_TXE] = 1;
    end
    txph = TX_DATA;
    txpar = char_parity(txsr);
    txbits = char_len();
  endtask

  task automatic restart_rx_sync(bit hunt, bit second);
    if (hunt) begin
      rxph = RX_HUNT;
      if (int_sync()) begin
        rxtag = second ? 2'd2 : 2'd1;
        rxsr = second ? syn2 : syn1;
        rxpar = char_parity(rxsr);
        rxbits = char_len() + (mode_reg[4] ? 4'd1 : 4'd0);
      end else begin
        rxtag = 2'd0;
      end
      stat[ST_RXR] = 0;
    end else begin
      rxph = RX_DATA;
      rxtag = second ? 2'd2 : 2'd1;
      rxbits = char_len();
      rxsr = '0;
    end
  endtask

  task automatic sync_matched(bit in_hunt);
    if (rxtag == 2'd1 && two_sync()) begin
      restart_rx_sync(in_hunt, 1);
    end else begin
      restart_rx_sync(0, 0);
      stat[ST_SYN] = 1;
    end
  endtask

  task automatic store_rx_char();
    rxh = rxsr;
    if (stat[ST_RXR]) stat[ST_OE] = 1;
    stat[ST_RXR] = 1;
  endtask

  task automatic finish_sync_char();
    store_rx_char();
    if ((rxtag == 2'd1 && rxsr == syn1) || (rxtag == 2'd2 && rxsr == syn2)) begin
      sync_matched(0);
    end else begin
      rxph = RX_DATA;
      rxbits = char_len();
      rxsr = '0;
    end
  endtask

  task automatic ctrl_write(logic [7:0] v);
    if (setup == 2'd0) begin
      mode_reg = v;
      rxbits = char_len() + (mode_reg[4] ? 4'd1 : 4'd0);
      txbits = char_len();
      stat = '0;
      stat[ST_TXE] = 1; stat[ST_TXR] = 1;
      rxph = RX_NONE; rxtag = '0; brkcnt = '0;
      txph = TX_NONE; txtag = '0; txbrk = 0;
      pins = PINS_RESET;
      if (is_sync()) begin
        setup = 2'd1;
      end else begin
        setup = 2'd3;
        load_async_char();
        rxph = RX_WAIT;
      end
    end else if (setup != 2'd3) begin
      if (setup == 2'd1) syn1 = v; else syn2 = v;
      if (setup == 2'd1 && two_sync()) begin
        setup = 2'd2;
      end else begin
        setup = 2'd3;
        load_sync_char();
        restart_rx_sync(1, 0);
      end
    end else begin
      cmd_reg = v;
      if (v[CMD_IRES]) begin
        setup = 2'd0;
        return;
      end
      if (v[CMD_ERST]) begin
        stat[ST_PE] = 0; stat[ST_OE] = 0; stat[ST_FE] = 0;
      end
      if (v[CMD_SBRK]) begin
        txbrk = 1;
        pins[P_TXD] = 0;
      end else if (txbrk) begin
        txbrk = 0;
        pins[P_TXD] = 1;
        if (is_sync()) load_sync_char(); else load_async_char();
      end
      if (is_sync() && v[CMD_HUNT]) restart_rx_sync(1, 0);
    end
  endtask

  task automatic txc_edge(logic lv);
    logic old;
    old = pins[P_TXC];
    pins[P_TXC] = lv;
    if (setup != 2'd3 || txbrk || old == lv || lv) return;
    if (is_sync()) begin
      if (txph == TX_DATA) begin
        if (!tx_allowed() && txbits == char_len()) return;
        pins[P_TXD] = txsr[0];
        txsr = txsr >> 1;
        txbits = txbits - 4'd1;
        if (txbits == 0) begin
          if (mode_reg[4]) txph = TX_PARITY; else load_sync_char();
        end
      end else if (txph == TX_PARITY) begin
        pins[P_TXD] = txpar;
        load_sync_char();
      end
      return;
    end
    if (txcnt > 1) begin
      txcnt = txcnt - 7'd1;
      return;
    end
    txcnt = clk_factor();
    case (txph)
      TX_START: begin
        if (!tx_allowed()) return;
        pins[P_TXD] = 0;
        txph = TX_DATA;
      end
      TX_DATA: begin
        pins[P_TXD] = txsr[0];
        txsr = txsr >> 1;
        txbits = txbits - 4'd1;
        if (txbits == 0) txph = mode_reg[4] ? TX_PARITY : TX_STOP;
      end
      TX_PARITY: begin
        pins[P_TXD] = txpar;
        txph = TX_STOP;
      end
      TX_STOP: begin
        pins[P_TXD] = 1;
        if (mode_reg[7:6] == 2'd2) txph = TX_STOP15;
        else if (mode_reg[7:6] == 2'd3) txph = TX_STOP2;
        else txph = TX_IDLE;
      end
      TX_STOP15, TX_STOP2: begin
        if (txph == TX_STOP15 && txcnt > 1) txcnt = txcnt >> 1;
        pins[P_TXD] = 1;
        txph = TX_IDLE;
      end
      TX_IDLE: begin
        load_async_char();
        if (txph == TX_START && tx_allowed()) begin
          pins[P_TXD] = 0;
          txph = TX_DATA;
        end
      end
      default: ;
    endcase
  endtask

  task automatic rxc_edge(logic lv);
    logic old, rxd;
    logic [6:0] f;
    logic [3:0] n;
    old = pins[P_RXC];
    rxd = pins[P_RXD];
    f = clk_factor();
    n = char_len();
    pins[P_RXC] = lv;
    if (setup != 2'd3 || old == lv || !lv) return;
    if (!is_sync()) begin
      if (rxcnt > 1) begin
        rxcnt = rxcnt - 7'd1;
        return;
      end
      rxcnt = f;
    end
    case (rxph)
      RX_HUNT: begin
        if (int_sync()) begin
          rxbits = rxbits - 4'd1;
          if (rxbits == 0 && mode_reg[4]) begin
            if (rxpar == rxd) sync_matched(1); else restart_rx_sync(1, 0);
          end else if (rxsr[0] == rxd) begin
            rxsr = rxsr >> 1;
            if (rxbits == 0) sync_matched(1);
          end else begin
            restart_rx_sync(1, 0);
          end
        end
      end
      RX_WAIT: begin
        if (!rxd && brkcnt > 0) begin
          rxph = RX_START;
          rxcnt = (f > 1) ? f >> 1 : f;
        end
      end
      RX_START: begin
        if (rxd) begin
          rxph = RX_WAIT;
        end else begin
          rxph = RX_DATA;
          rxsr = '0;
          rxbits = n;
        end
      end
      RX_DATA: begin
        rxsr = {rxd, rxsr[7:1]};
        rxbits = rxbits - 4'd1;
        if (rxbits == 0) begin
          if (n < 8) rxsr = rxsr >> (4'd8 - n);
          if (mode_reg[4]) begin
            rxph = RX_PARITY;
            rxpar = char_parity(rxsr);
          end else if (is_sync()) begin
            finish_sync_char();
          end else begin
            rxph = RX_STOP;
          end
        end
      end
      RX_PARITY: begin
        if (rxd != rxpar) stat[ST_PE] = 1;
        if (is_sync()) finish_sync_char(); else rxph = RX_STOP;
      end
      RX_STOP: begin
        if (!rxd) begin
          stat[ST_FE] = 1;
          brkcnt = brkcnt + 2'd1;
          if (brkcnt > 1) begin
            brkcnt = 2'd2;
            stat[ST_BRK] = 1;
          end
        end
        store_rx_char();
        rxph = RX_WAIT;
      end
      default: ;
    endcase
  endtask

  task automatic apply_event(input in_word_t ev, output usart_result_t r);
    logic [6:0] f;
    r.rd = NO_READ;
    case (ev.operation)
      OP_WR_CTRL: ctrl_write(ev.data);
      OP_WR_DATA: begin
        if (setup == 2'd3) begin
          txh = ev.data;
          stat[ST_TXE] = 0;
          stat[ST_TXR] = 0;
        end
      end
      OP_RD_STAT: begin
        r.rd = {~pins[P_DSR], stat[6:0]};
        if (int_sync()) stat[ST_SYN] = 0;
      end
      OP_RD_DATA: begin
        if (stat[ST_RXR]) begin
          r.rd = rxh;
          stat[ST_RXR] = 0;
        end
      end
      OP_RXD: begin
        f = clk_factor();
        if (!is_sync() && rxph == RX_WAIT && pins[P_RXD] && !ev.level) begin
          rxph = RX_START;
          rxcnt = (f > 1) ? f >> 1 : f;
        end
        if (!is_sync() && ev.level) begin
          stat[ST_BRK] = 0;
          brkcnt = '0;
        end
        pins[P_RXD] = ev.level;
      end
      OP_TXC: txc_edge(ev.level);
      OP_RXC: rxc_edge(ev.level);
      OP_DSR: pins[P_DSR] = ev.level;
      OP_CTS: pins[P_CTS] = ev.level;
      OP_SYNDET: begin
        if (is_sync() && mode_reg[6] && stat[ST_SYN] != ev.level) begin
          stat[ST_SYN] = ev.level;
          if (ev.level) restart_rx_sync(0, 0);
        end
      end
      default: ;
    endcase
    if (int_sync()) r.syn_brk = stat[ST_SYN];
    else if (!is_sync()) r.syn_brk = stat[ST_BRK];
    else r.syn_brk = 0;
    r.txd = pins[P_TXD];
    r.txrdy = stat[ST_TXR] && cmd_reg[CMD_TXEN] && !pins[P_CTS];
    r.txempty = stat[ST_TXE];
    r.rxrdy = stat[ST_RXR];
    r.dtr_n = ~cmd_reg[CMD_DTR];
    r.rts_n = ~cmd_reg[CMD_RTS];
    r.phase = setup;
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic push_ev(logic [3:0] op, logic [7:0] d, logic lv);
    in_word_t w;
    w.pad = '0;
    w.operation = op;
    w.level = lv;
    w.data = d;
    pending_events.push_back(w);
  endtask

  task automatic pulse_rxc(int count);
    repeat (count) begin
      push_ev(OP_RXC, 8'($urandom), 1'b1);
      push_ev(OP_RXC, 8'($urandom), 1'b0);
    end
  endtask

  task automatic pulse_txc(int count);
    repeat (count) begin
      push_ev(OP_TXC, 8'($urandom), 1'b0);
      push_ev(OP_TXC, 8'($urandom), 1'b1);
    end
  endtask

  function automatic logic frame_parity(logic [7:0] m, logic [7:0] v);
    logic [7:0] mask;
    mask = 8'hFF >> (3'd3 - m[3:2]);
    return m[5] ? ^(v & mask) : ~^(v & mask);
  endfunction

  // async serial frame on rxd, one bit per factor rxc periods
  task automatic send_async_frame(logic [7:0] m, logic [7:0] v, int f);
    logic p;
    p = frame_parity(m, v) ^ ($urandom_range(0, 7) == 0);
    push_ev(OP_RXD, 8'($urandom), 1'b0);
    pulse_rxc(f);
    for (int i = 0; i < m[3:2] + 5; i++) begin
      push_ev(OP_RXD, 8'($urandom), v[i]);
      pulse_rxc(f);
    end
    if (m[4]) begin
      push_ev(OP_RXD, 8'($urandom), p);
      pulse_rxc(f);
    end
    push_ev(OP_RXD, 8'($urandom), $urandom_range(0, 9) != 0);
    pulse_rxc(f);
    push_ev(OP_RXD, 8'($urandom), 1'b1);
  endtask

  // sync character: data bits then optional parity, one rxc period each
  task automatic send_sync_char(logic [7:0] m, logic [7:0] v);
    for (int i = 0; i < m[3:2] + 5; i++) begin
      push_ev(OP_RXD, 8'($urandom), v[i]);
      pulse_rxc(1);
    end
    if (m[4]) begin
      push_ev(OP_RXD, 8'($urandom), frame_parity(m, v) ^ ($urandom_range(0, 7) == 0));
      pulse_rxc(1);
    end
  endtask

  task automatic run_session(bit first);
    logic [7:0] m, s1, s2, c;
    int f, len, start;
    bit sync_mode;
    if (!first) push_ev(OP_WR_CTRL, CMD_IRES_WORD, 1'($urandom));
    sync_mode = $urandom_range(0, 3) == 0;
    m = 8'($urandom);
    s1 = 8'($urandom);
    s2 = 8'($urandom);
    if (sync_mode) begin
      m[1:0] = 2'd0;
      m[6] = $urandom_range(0, 3) == 0;
      f = 1;
    end else begin
      case ($urandom_range(0, 11))
        0: m[1:0] = 2'd3;
        1, 2: m[1:0] = 2'd2;
        default: m[1:0] = 2'd1;
      endcase
      f = (m[1:0] == 2'd1) ? 1 : (m[1:0] == 2'd2) ? 16 : 64;
    end
    push_ev(OP_WR_CTRL, m, 1'($urandom));
    if (sync_mode) begin
      push_ev(OP_WR_CTRL, s1, 1'($urandom));
      if (!m[7]) push_ev(OP_WR_CTRL, s2, 1'($urandom));
    end
    c = 8'($urandom);
    c[CMD_IRES] = 0;
    c[CMD_TXEN] = $urandom_range(0, 7) != 0;
    c[CMD_SBRK] = $urandom_range(0, 7) == 0;
    push_ev(OP_WR_CTRL, c, 1'($urandom));
    push_ev(OP_CTS, 8'($urandom), 1'b0);
    len = $urandom_range(40, 140);
    start = pending_events.size();
    while (pending_events.size() - start < len) begin
      case ($urandom_range(0, 19))
        0, 1, 2: push_ev(OP_WR_DATA, 8'($urandom), 1'($urandom));
        3, 4, 5, 6: pulse_txc((f == 1) ? $urandom_range(1, 12) : $urandom_range(1, 40));
        7, 8, 9, 10: begin
          if (sync_mode) begin
            case ($urandom_range(0, 2))
              0: send_sync_char(m, s1);
              1: send_sync_char(m, m[7] ? s1 : s2);
              default: send_sync_char(m, 8'($urandom));
            endcase
          end else if (f <= 16) begin
            send_async_frame(m, 8'($urandom), f);
          end else begin
            pulse_rxc($urandom_range(1, 20));
          end
        end
        11, 12: push_ev(OP_RD_STAT, 8'($urandom), 1'($urandom));
        13, 14: push_ev(OP_RD_DATA, 8'($urandom), 1'($urandom));
        15: push_ev($urandom_range(0, 1) ? OP_CTS : OP_DSR, 8'($urandom),
                    $urandom_range(0, 3) == 0);
        16: push_ev(OP_SYNDET, 8'($urandom), 1'($urandom));
        17: begin
          c = 8'($urandom);
          c[CMD_IRES] = 0;
          push_ev(OP_WR_CTRL, c, 1'($urandom));
        end
        18: push_ev(4'($urandom_range(1, 15)), 8'($urandom), 1'($urandom));
        default: push_ev(OP_RXD, 8'($urandom), 1'($urandom));
      endcase
    end
  endtask

  task automatic build_stimulus();
    // unused codes, writes and clocks before setup, empty data read
    push_ev(4'd10, 8'hFF, 1'b1);
    push_ev(4'd15, 8'h00, 1'b0);
    push_ev(OP_WR_DATA, 8'hA5, 1'b0);
    push_ev(OP_RD_DATA, 8'h00, 1'b0);
    push_ev(OP_RD_STAT, 8'h00, 1'b0);
    push_ev(OP_TXC, 8'h00, 1'b1);
    push_ev(OP_TXC, 8'h00, 1'b0);
    push_ev(OP_RXC, 8'h00, 1'b1);
    push_ev(OP_RXC, 8'h00, 1'b0);
    push_ev(OP_DSR, 8'h00, 1'b0);
    // async x1, 8 bits even parity, 2 stops, all command bits but reset
    push_ev(OP_WR_CTRL, 8'hFD, 1'b0);
    push_ev(OP_WR_CTRL, 8'hBF, 1'b0);
    push_ev(OP_WR_CTRL, 8'h37, 1'b0);
    push_ev(OP_CTS, 8'h00, 1'b0);
    push_ev(OP_WR_DATA, 8'hFF, 1'b1);
    pulse_txc(6);
    push_ev(OP_WR_DATA, 8'h00, 1'b0);
    push_ev(OP_RD_STAT, 8'h00, 1'b0);
    push_ev(OP_WR_CTRL, CMD_IRES_WORD, 1'b0);
    // sync, two sync chars, then enter hunt
    push_ev(OP_WR_CTRL, 8'h00, 1'b0);
    push_ev(OP_WR_CTRL, 8'h16, 1'b0);
    push_ev(OP_WR_CTRL, 8'h16, 1'b0);
    push_ev(OP_WR_CTRL, 8'hB7, 1'b0);
    push_ev(OP_SYNDET, 8'h00, 1'b1);
    push_ev(OP_RD_DATA, 8'h00, 1'b0);
    while (pending_events.size() < 1750)
      run_session(0);
  endtask

  // ------------------------------------------------------- driver and monitor
  function automatic int sender_idle_pct();
    int ph;
    ph = accepted_events * 3 / total_events;
    return (ph == 0) ? 37 : (ph == 1) ? 84 : 0;
  endfunction

  function automatic int receiver_idle_pct();
    int ph;
    ph = accepted_events * 3 / total_events;
    return (ph == 0) ? 84 : (ph == 1) ? 37 : 0;
  endfunction

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || took) begin
        if (pending_events.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          {in_tuser, in_tdata} <= pending_events.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= $urandom_range(0, 99) >= receiver_idle_pct();
    end
  end

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    usart_result_t exp_r, act_r, pred_r;
    if (rst_n) begin
      took = in_tvalid && in_tready;
      if (took) begin
        apply_event(in_word_t'({in_tuser, in_tdata}), pred_r);
        expected_results.push_back(pred_r);
        accepted_events++;
      end
      if (out_tvalid && out_tready) begin
        act_r = usart_result_t'(out_tdata[16:0]);
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result transaction with none expected, actual %0h",
                   $realtime, out_tdata);
        end else begin
          exp_r = expected_results.pop_front();
          check_field("read_value", exp_r.rd, act_r.rd);
          check_field("txd", exp_r.txd, act_r.txd);
          check_field("txrdy", exp_r.txrdy, act_r.txrdy);
          check_field("txempty", exp_r.txempty, act_r.txempty);
          check_field("rxrdy", exp_r.rxrdy, act_r.rxrdy);
          check_field("dtr_n", exp_r.dtr_n, act_r.dtr_n);
          check_field("rts_n", exp_r.rts_n, act_r.rts_n);
          check_field("syn_brk", exp_r.syn_brk, act_r.syn_brk);
          check_field("setup_phase", exp_r.phase, act_r.phase);
        end
      end
    end
  end

  initial begin
    reset_model();
    build_stimulus();
    total_events = pending_events.size();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    while (pending_events.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
